### hdl/tdce_pkg.sv
package tdce_pkg;

	localparam int DICT_BYTES    = 4096;
	localparam int MAX_TOKENS    = 2048;
	localparam int MAX_ENTRY_LEN = 64;
	localparam int DICT_ENTRIES  = 128;

	localparam int DICT_AW = $clog2(DICT_BYTES);
	localparam int FILL_W  = $clog2(DICT_BYTES + 1);
	localparam int LEN_W   = $clog2(MAX_ENTRY_LEN + 1);
	localparam int ENT_AW  = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
	localparam int LOAD_W  = $clog2(DICT_ENTRIES + 1);
	localparam int ENT_W   = DICT_AW + LEN_W;
	localparam int SUM_W   = ((FILL_W > 16) ? FILL_W : 16) + 1;

	localparam int MIN_CONTAINER = 44;
	localparam int BITMAP_BYTES  = 32;
	localparam logic [7:0] TOKEN_BASE   = 8'h80;
	localparam logic [7:0] VERSION_BYTE = 8'h05;
	localparam logic [7:0] MAGIC_BYTES [4] = '{8'h48, 8'h42, 8'h43, 8'h35};

	localparam logic IK_CONTAINER = 1'b0;
	localparam logic IK_STRING    = 1'b1;
	localparam logic RK_BYTE      = 1'b0;
	localparam logic RK_STATUS    = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FORMAT   = 2'd1,
		ST_CAPACITY = 2'd2
	} status_t;

	typedef enum logic [9:0] {
		PH_MAGIC   = 10'b00_0000_0001,
		PH_VERSION = 10'b00_0000_0010,
		PH_FLAGS   = 10'b00_0000_0100,
		PH_COUNT   = 10'b00_0000_1000,
		PH_BITMAP  = 10'b00_0001_0000,
		PH_HEAD    = 10'b00_0010_0000,
		PH_TEXT    = 10'b00_0100_0000,
		PH_PSIZE   = 10'b00_1000_0000,
		PH_PAYLOAD = 10'b01_0000_0000,
		PH_ERROR   = 10'b10_0000_0000
	} phase_t;

	typedef enum logic [2:0] {
		EX_IDLE  = 3'b001,
		EX_ENTRY = 3'b010,
		EX_EMIT  = 3'b100
	} exp_state_t;

endpackage

### hdl/tdce_in_if.sv
interface tdce_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic       end_mark;

	modport source(output valid, kind, data_byte, end_mark, input ready);
	modport sink(input valid, kind, data_byte, end_mark, output ready);
endinterface

### hdl/tdce_out_if.sv
interface tdce_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic        end_of_string;
	logic [1:0]  status;
	logic [7:0]  header_flags;
	logic [31:0] payload_length;
	logic [31:0] header_length;

	modport source(output valid, result_kind, out_byte, last_of_run, end_of_string, status,
		header_flags, payload_length, header_length, input ready);
	modport sink(input valid, result_kind, out_byte, last_of_run, end_of_string, status,
		header_flags, payload_length, header_length, output ready);
endinterface

### hdl/token_dictionary_container_expander_core.sv
// Container bytes are parsed as they are taken; the byte carrying the end mark also places
// the status report in the output register. A literal string byte goes straight to the
// output register. A string byte that hits a loaded dictionary entry reads the entry table,
// then its text bytes one by one through the single dictionary memory port and the one output
// register; an empty entry gives no result. A new byte is taken only once the last read of the
// previous expansion has reached the output register and that register is free.
module token_dictionary_container_expander_core (
	input  logic       clk,
	input  logic       arst_n,
	tdce_in_if.sink    in_ch,
	tdce_out_if.source out_ch
);
	import tdce_pkg::*;

	phase_t      phase_q, n_phase;
	logic [31:0] fc_q, n_fc;
	logic [31:0] fo_q, n_fo;
	logic [15:0] decl_q, n_decl;
	logic [15:0] tok_q, n_tok;
	logic [15:0] rl_q, n_rl;
	logic [FILL_W-1:0] fill_q, n_fill;
	logic [7:0]  flags_q, n_flags;
	logic [31:0] pdecl_q, n_pdecl;
	logic [31:0] hend_q, n_hend;
	logic [1:0]  fault_q, n_fault;
	logic        tf_q, n_tf;
	logic [LOAD_W-1:0] loaded_q, n_loaded;
	logic        dvalid_q, n_dvalid;
	logic [7:0]  bitmap_q [BITMAP_BYTES];

	logic        bm_we;
	logic [4:0]  bm_idx;
	logic        dict_we;
	logic [DICT_AW-1:0] dict_waddr;
	logic        ent_we;
	logic [ENT_W-1:0] ent_wdata;
	logic [1:0]  rep_status;

	exp_state_t  st_q;
	logic [DICT_AW-1:0] start_q;
	logic [LEN_W-1:0]   len_q, i_q;
	logic        mark_q;
	logic        rd_s1, last_s1;

	logic        in_fire, c_fire, s_fire, hit, rd_issue;
	logic [ENT_W-1:0]   ent_rdata;
	logic [DICT_AW-1:0] ent_start;
	logic [LEN_W-1:0]   ent_len;
	logic [7:0]  dict_rdata;
	logic [DICT_AW-1:0] dict_addr;
	logic [ENT_AW-1:0]  ent_addr;

	logic        out_v_q, okind_q, olast_q, oeos_q;
	logic [7:0]  obyte_q, oflags_q;
	logic [1:0]  ost_q;
	logic [31:0] opl_q, ohl_q;

	assign in_fire = in_ch.valid && in_ch.ready;
	assign c_fire  = in_fire && (in_ch.kind == IK_CONTAINER);
	assign s_fire  = in_fire && (in_ch.kind == IK_STRING);
	assign hit = (in_ch.data_byte >= TOKEN_BASE) && dvalid_q &&
		bitmap_q[in_ch.data_byte[7:3]][in_ch.data_byte[2:0]] &&
		(LOAD_W'(in_ch.data_byte[6:0]) < loaded_q);
	assign in_ch.ready = (st_q == EX_IDLE) && !rd_s1 && (!out_v_q || out_ch.ready);
	assign rd_issue = (st_q == EX_EMIT) && !rd_s1 && (!out_v_q || out_ch.ready);

	always_comb begin
		logic [15:0] rl_new;
		logic        tf_new;
		n_phase = phase_q; n_fc = fc_q; n_fo = fo_q; n_decl = decl_q; n_tok = tok_q;
		n_rl = rl_q; n_fill = fill_q; n_flags = flags_q; n_pdecl = pdecl_q;
		n_hend = hend_q; n_fault = fault_q; n_tf = tf_q; n_loaded = loaded_q;
		n_dvalid = dvalid_q;
		bm_we = 1'b0; bm_idx = fc_q[4:0];
		dict_we = 1'b0; dict_waddr = DICT_AW'(fill_q) + DICT_AW'(fc_q);
		ent_we = 1'b0; ent_wdata = '0;
		rep_status = ST_OK;
		rl_new = rl_q; tf_new = tf_q;
		if (c_fire) begin
			if (phase_q == PH_MAGIC && fc_q == '0 && fo_q == '0) begin
				n_dvalid = 1'b0; n_loaded = '0; n_fill = '0; n_tok = '0; n_decl = '0;
				n_rl = '0; n_flags = '0; n_pdecl = '0; n_hend = '0;
			end
			unique case (phase_q)
				PH_MAGIC: begin
					if (in_ch.data_byte != MAGIC_BYTES[fc_q[1:0]]) begin
						n_fault = ST_FORMAT; n_phase = PH_ERROR;
					end else if (fc_q[1:0] == 2'd3) begin
						n_fc = '0; n_phase = PH_VERSION;
					end else
						n_fc = fc_q + 32'd1;
				end
				PH_VERSION: begin
					if (in_ch.data_byte != VERSION_BYTE) begin
						n_fault = ST_FORMAT; n_phase = PH_ERROR;
					end else
						n_phase = PH_FLAGS;
				end
				PH_FLAGS: begin
					n_flags = in_ch.data_byte; n_fc = '0; n_phase = PH_COUNT;
				end
				PH_COUNT: begin
					if (fc_q == '0) begin
						n_decl = {8'd0, in_ch.data_byte}; n_fc = 32'd1;
					end else begin
						n_decl = {in_ch.data_byte, decl_q[7:0]}; n_fc = '0;
						if (n_decl > 16'(MAX_TOKENS)) begin
							n_fault = ST_CAPACITY; n_phase = PH_ERROR;
						end else
							n_phase = PH_BITMAP;
					end
				end
				PH_BITMAP: begin
					bm_we = 1'b1;
					n_fc = fc_q + 32'd1;
					if (fc_q[4:0] == 5'(BITMAP_BYTES - 1)) begin
						n_fc = '0;
						n_phase = (decl_q == '0) ? PH_PSIZE : PH_HEAD;
					end
				end
				PH_HEAD: begin
					if (fc_q[1:0] == 2'd2)
						rl_new = {8'd0, in_ch.data_byte};
					else if (fc_q[1:0] == 2'd3)
						rl_new = {in_ch.data_byte, rl_q[7:0]};
					n_rl = rl_new;
					n_fc = fc_q + 32'd1;
					if (fc_q[1:0] == 2'd3) begin
						n_fc = '0;
						tf_new = (SUM_W'(fill_q) + SUM_W'(rl_new) > SUM_W'(DICT_BYTES)) ||
							(rl_new > 16'(MAX_ENTRY_LEN));
						n_tf = tf_new;
						if (!tf_new && tok_q < 16'(DICT_ENTRIES)) begin
							ent_we = 1'b1;
							ent_wdata = {DICT_AW'(fill_q), LEN_W'(rl_new)};
						end
						if (rl_new == '0) begin
							if (tf_new) begin
								n_fault = ST_CAPACITY; n_phase = PH_ERROR;
							end else begin
								n_tok = tok_q + 16'd1;
								n_phase = (n_tok >= decl_q) ? PH_PSIZE : PH_HEAD;
							end
						end else
							n_phase = PH_TEXT;
					end
				end
				PH_TEXT: begin
					dict_we = !tf_q;
					n_fc = fc_q + 32'd1;
					if (n_fc >= {16'd0, rl_q}) begin
						if (tf_q) begin
							n_fault = ST_CAPACITY; n_phase = PH_ERROR;
						end else begin
							n_fill = fill_q + FILL_W'(rl_q);
							n_tok = tok_q + 16'd1;
							n_fc = '0;
							n_phase = (n_tok >= decl_q) ? PH_PSIZE : PH_HEAD;
						end
					end
				end
				PH_PSIZE: begin
					n_pdecl = ((fc_q == '0) ? 32'd0 : pdecl_q) |
						(32'(in_ch.data_byte) << {fc_q[1:0], 3'd0});
					n_fc = fc_q + 32'd1;
					if (fc_q[1:0] == 2'd3) begin
						n_fc = '0;
						n_hend = (fo_q == '1) ? fo_q : fo_q + 32'd1;
						n_phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (fc_q != '1)
						n_fc = fc_q + 32'd1;
				end
				PH_ERROR: begin
				end
				default: begin
				end
			endcase
			if (fo_q != '1)
				n_fo = fo_q + 32'd1;
			if (in_ch.end_mark) begin
				if (n_fo < 32'(MIN_CONTAINER))
					rep_status = ST_FORMAT;
				else if (n_phase == PH_ERROR)
					rep_status = n_fault;
				else if (n_phase != PH_PAYLOAD)
					rep_status = ST_FORMAT;
				else if (n_fc < n_pdecl)
					rep_status = ST_FORMAT;
				if (rep_status == ST_OK) begin
					n_dvalid = 1'b1;
					n_loaded = (n_decl < 16'(DICT_ENTRIES)) ? LOAD_W'(n_decl) :
						LOAD_W'(DICT_ENTRIES);
				end
				n_phase = PH_MAGIC; n_fc = '0; n_fo = '0; n_fault = ST_OK; n_tf = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC; fc_q <= '0; fo_q <= '0; decl_q <= '0; tok_q <= '0;
			rl_q <= '0; fill_q <= '0; flags_q <= '0; pdecl_q <= '0; hend_q <= '0;
			fault_q <= ST_OK; tf_q <= 1'b0; loaded_q <= '0; dvalid_q <= 1'b0;
			for (int k = 0; k < BITMAP_BYTES; k++)
				bitmap_q[k] <= '0;
		end else begin
			phase_q <= n_phase; fc_q <= n_fc; fo_q <= n_fo; decl_q <= n_decl;
			tok_q <= n_tok; rl_q <= n_rl; fill_q <= n_fill; flags_q <= n_flags;
			pdecl_q <= n_pdecl; hend_q <= n_hend; fault_q <= n_fault; tf_q <= n_tf;
			loaded_q <= n_loaded; dvalid_q <= n_dvalid;
			if (bm_we)
				bitmap_q[bm_idx] <= in_ch.data_byte;
		end
	end

	assign ent_addr  = ent_we ? ENT_AW'(tok_q) : ENT_AW'(in_ch.data_byte[6:0]);
	assign dict_addr = dict_we ? dict_waddr : start_q + DICT_AW'(i_q);
	assign ent_start = ent_rdata[ENT_W-1:LEN_W];
	assign ent_len   = ent_rdata[LEN_W-1:0];

	tdce_ram #(.WIDTH(ENT_W), .DEPTH(DICT_ENTRIES)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.addr  (ent_addr),
		.wdata (ent_wdata),
		.rdata (ent_rdata)
	);

	tdce_ram #(.WIDTH(8), .DEPTH(DICT_BYTES)) u_dict_ram (
		.clk   (clk),
		.we    (dict_we),
		.addr  (dict_addr),
		.wdata (in_ch.data_byte),
		.rdata (dict_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= EX_IDLE;
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= rd_issue;
			unique case (st_q)
				EX_IDLE: begin
					if (s_fire && hit)
						st_q <= EX_ENTRY;
				end
				EX_ENTRY: begin
					st_q <= (ent_len == '0) ? EX_IDLE : EX_EMIT;
				end
				EX_EMIT: begin
					if (rd_issue && (i_q + LEN_W'(1) == len_q))
						st_q <= EX_IDLE;
				end
				default: st_q <= EX_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire)
			mark_q <= in_ch.end_mark;
		if (st_q == EX_ENTRY) begin
			start_q <= ent_start;
			len_q <= ent_len;
			i_q <= '0;
		end else if (rd_issue)
			i_q <= i_q + LEN_W'(1);
		if (rd_issue)
			last_s1 <= (i_q + LEN_W'(1) == len_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if ((c_fire && in_ch.end_mark) || (s_fire && !hit) || rd_s1)
			out_v_q <= 1'b1;
		else if (out_ch.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (c_fire && in_ch.end_mark) begin
			okind_q <= RK_STATUS; obyte_q <= '0; olast_q <= 1'b1; oeos_q <= 1'b0;
			ost_q <= rep_status;
			oflags_q <= (rep_status == ST_OK) ? n_flags : '0;
			opl_q <= (rep_status == ST_OK) ? n_pdecl : '0;
			ohl_q <= (rep_status == ST_OK) ? n_hend : '0;
		end else if (s_fire && !hit) begin
			okind_q <= RK_BYTE; obyte_q <= in_ch.data_byte; olast_q <= 1'b1;
			oeos_q <= in_ch.end_mark; ost_q <= ST_OK; oflags_q <= '0;
			opl_q <= '0; ohl_q <= '0;
		end else if (rd_s1) begin
			okind_q <= RK_BYTE; obyte_q <= dict_rdata; olast_q <= last_s1;
			oeos_q <= last_s1 & mark_q; ost_q <= ST_OK; oflags_q <= '0;
			opl_q <= '0; ohl_q <= '0;
		end
	end

	assign out_ch.valid          = out_v_q;
	assign out_ch.result_kind    = okind_q;
	assign out_ch.out_byte       = obyte_q;
	assign out_ch.last_of_run    = olast_q;
	assign out_ch.end_of_string  = oeos_q;
	assign out_ch.status         = ost_q;
	assign out_ch.header_flags   = oflags_q;
	assign out_ch.payload_length = opl_q;
	assign out_ch.header_length  = ohl_q;

	a_ready_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !rd_s1)
		else $error("input taken while a dictionary read is pending");
	a_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(dict_we && rd_issue))
		else $error("dictionary write collides with expansion read");
	a_hit_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && hit) |=> (st_q == EX_ENTRY))
		else $error("dictionary hit did not start entry lookup");
	a_read_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> $past(st_q == EX_EMIT))
		else $error("dictionary read outside emit");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && okind_q == RK_STATUS) |-> (ost_q != 2'd3))
		else $error("undefined status code");
endmodule

### hdl/tdce_ram.sv
module tdce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
